// ----- hw/rtl/pdm_pkg.sv -----
// Package for the PWM duty-cycle capture block: request codes, field widths
// and divider sizing shared by the interfaces and the top level.
// Depends on nothing.
package pdm_pkg;

    // Field widths of the request and result words.
    localparam int REQ_TYPE_W = 2;
    localparam int CAP_W      = 16;
    localparam int DUTY_W     = 7;

    // Default width of the saturating overflow counter.
    localparam int OVF_COUNT_BITS_DEF = 16;

    // Interval and divider widths.
    localparam int INTV_W    = 32;
    localparam int TOTAL_W   = INTV_W + 1;
    localparam int NUM_W     = INTV_W + DUTY_W;
    localparam int DIV_STEPS = DUTY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CAPTURE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_OVF     = 2'd2;

    // Full-scale duty value.
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

endpackage

// ----- hw/rtl/pdm_ifs.sv -----
// Valid/ready channel interfaces for the PWM duty-cycle capture block.
// Depends on pdm_pkg.
interface pdm_req_if import pdm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [CAP_W-1:0]      capture_value;

    modport source (output valid, req_type, capture_value, input ready);
    modport sink   (input valid, req_type, capture_value, output ready);
endinterface

interface pdm_res_if import pdm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              capture_rising_edge;
    logic              done_res;
    logic [DUTY_W-1:0] duty_percent;

    modport source (output valid, capture_rising_edge, done_res, duty_percent, input ready);
    modport sink   (input valid, capture_rising_edge, done_res, duty_percent, output ready);
endinterface

// ----- hw/rtl/pwm_duty_measure_capture.sv -----
// PWM duty-cycle measurement from input-capture events. A start word arms the
// block; three capture words (rising, falling, rising) follow, with overflow
// ticks in between each adding 65536 timer clocks to the current interval.
// Every request word gives exactly one result word. Start, overflow and the
// first two capture words answer in the next cycle; the closing capture word
// forms high*100 and high+low in a set-up state, then takes seven steps of a
// shared restoring compare-and-subtract unit, one quotient bit per step. A
// finished result waits in an output register; a new request word is accepted
// only once it is free or being read. Depends on pdm_pkg and pdm_ifs.
module pwm_duty_measure_capture import pdm_pkg::*; #(
    parameter int OVF_COUNT_BITS = OVF_COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pdm_req_if.sink   req,
    pdm_res_if.source res
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // Measurement phases.
    localparam logic [1:0] PH_WAIT_RISE1 = 2'd0;
    localparam logic [1:0] PH_WAIT_FALL  = 2'd1;
    localparam logic [1:0] PH_WAIT_RISE2 = 2'd2;
    localparam logic [1:0] PH_IDLE       = 2'd3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [1:0]                state_reg, state_next;
    logic [1:0]                phase_reg, phase_next;
    logic [CAP_W-1:0]          first_stamp_reg, first_stamp_next;
    logic [CAP_W-1:0]          second_stamp_reg, second_stamp_next;
    logic [INTV_W-1:0]         high_time_reg, high_time_next;
    logic [INTV_W-1:0]         low_time_reg, low_time_next;
    logic [OVF_COUNT_BITS-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic                      edge_sel_reg, edge_sel_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          dvs_reg, dvs_next;
    logic [DUTY_W-1:0]         quot_reg, quot_next;
    logic                      zero_reg, zero_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_edge_reg, out_edge_next;
    logic                      out_done_reg, out_done_next;
    logic [DUTY_W-1:0]         out_duty_reg, out_duty_next;

    logic                      in_fire;
    logic [CAP_W-1:0]          prev_stamp;
    logic [INTV_W-1:0]         interval;
    logic [TOTAL_W-1:0]        total;
    logic [NUM_W-1:0]          high_ext;
    logic [NUM_W-1:0]          num;
    logic                      div_ge;
    logic [NUM_W-1:0]          rem_sub;

    // Accept only when idle and the result slot is free or draining.
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || res.ready);
    assign in_fire   = req.valid && req.ready;

    assign res.valid               = out_valid_reg;
    assign res.capture_rising_edge = out_edge_reg;
    assign res.done_res            = out_done_reg;
    assign res.duty_percent        = out_duty_reg;

    // Interval since the previous stamp, including counted overflows.
    assign prev_stamp = (phase_reg == PH_WAIT_FALL) ? first_stamp_reg : second_stamp_reg;
    assign interval   = INTV_W'(req.capture_value) - INTV_W'(prev_stamp)
                      + {CAP_W'(ovf_cnt_reg), {CAP_W{1'b0}}};

    // Dividend and divisor set-up: high*100 and high+low.
    assign total    = TOTAL_W'(high_time_reg) + TOTAL_W'(low_time_reg);
    assign high_ext = NUM_W'(high_time_reg);
    assign num      = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);

    // Shared compare-and-subtract unit of the restoring divider.
    assign div_ge  = (rem_reg >= dvs_reg);
    assign rem_sub = rem_reg - dvs_reg;

    // Next-state logic for the sequencer, measurement state and result slot.
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        first_stamp_next  = first_stamp_reg;
        second_stamp_next = second_stamp_reg;
        high_time_next    = high_time_reg;
        low_time_next     = low_time_reg;
        ovf_cnt_next      = ovf_cnt_reg;
        edge_sel_next     = edge_sel_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        quot_next         = quot_reg;
        zero_next         = zero_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg;
        out_edge_next     = out_edge_reg;
        out_done_next     = out_done_reg;
        out_duty_next     = out_duty_reg;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Most words answer at once; the closing capture defers.
                    out_valid_next = 1'b1;
                    out_done_next  = 1'b0;
                    out_duty_next  = '0;
                    case (req.req_type)
                        REQ_START:
                        begin
                            phase_next    = PH_WAIT_RISE1;
                            edge_sel_next = 1'b1;
                        end
                        REQ_OVF:
                        begin
                            if (ovf_cnt_reg != {OVF_COUNT_BITS{1'b1}})
                            begin
                                ovf_cnt_next = ovf_cnt_reg + 1'b1;
                            end
                        end
                        REQ_CAPTURE:
                        begin
                            case (phase_reg)
                                PH_WAIT_RISE1:
                                begin
                                    first_stamp_next = req.capture_value;
                                    ovf_cnt_next     = '0;
                                    edge_sel_next    = 1'b0;
                                    phase_next       = PH_WAIT_FALL;
                                end
                                PH_WAIT_FALL:
                                begin
                                    high_time_next    = interval;
                                    second_stamp_next = req.capture_value;
                                    ovf_cnt_next      = '0;
                                    edge_sel_next     = 1'b1;
                                    phase_next        = PH_WAIT_RISE2;
                                end
                                PH_WAIT_RISE2:
                                begin
                                    low_time_next  = interval;
                                    ovf_cnt_next   = '0;
                                    phase_next     = PH_IDLE;
                                    out_valid_next = 1'b0;
                                    state_next     = ST_MUL;
                                end
                                default:
                                begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    out_edge_next = edge_sel_next;
                end
            end
            ST_MUL:
            begin
                rem_next   = num;
                dvs_next   = NUM_W'(total) << (DIV_STEPS - 1);
                zero_next  = (total == '0);
                quot_next  = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // One quotient bit per step; the quotient never exceeds 100.
                if (div_ge)
                begin
                    rem_next = rem_sub;
                end
                quot_next = {quot_reg[DUTY_W-2:0], div_ge};
                dvs_next  = dvs_reg >> 1;
                if (step_reg == STEP_LAST)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = 1'b1;
                    out_duty_next  = zero_reg ? '0 : quot_next;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and measurement state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IDLE;
            first_stamp_reg  <= '0;
            second_stamp_reg <= '0;
            high_time_reg    <= '0;
            low_time_reg     <= '0;
            ovf_cnt_reg      <= '0;
            edge_sel_reg     <= 1'b1;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            first_stamp_reg  <= first_stamp_next;
            second_stamp_reg <= second_stamp_next;
            high_time_reg    <= high_time_next;
            low_time_reg     <= low_time_next;
            ovf_cnt_reg      <= ovf_cnt_next;
            edge_sel_reg     <= edge_sel_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Divider datapath and result payload.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        quot_reg     <= quot_next;
        zero_reg     <= zero_next;
        out_edge_reg <= out_edge_next;
        out_done_reg <= out_done_next;
        out_duty_reg <= out_duty_next;
    end

    // A completed measurement never reports more than full scale.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_duty_reg <= DUTY_FULL)
        else $error("duty result above full scale");

    // A word that did not complete a measurement reports zero duty.
    a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_done_reg |-> out_duty_reg == '0)
        else $error("nonzero duty on a word without a measurement");

    // The last divider step always delivers a completed result.
    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && step_reg == STEP_LAST |=> out_valid_reg && out_done_reg)
        else $error("divider finished without a result");

    // The result slot stays empty while the divider works.
    a_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("result pending during a division");

endmodule

// ----- tb/tb_pwm_duty_measure_capture.sv -----
`timescale 1ns / 100ps
// Testbench for pwm_duty_measure_capture: drives request words, predicts each
// result word with a local duty-cycle model and checks it field by field.
// Depends on pdm_pkg, pdm_ifs and the block itself.
module tb_pwm_duty_measure_capture import pdm_pkg::*; ();

    // Request code that has no meaning; the block must ignore it.
    localparam logic [REQ_TYPE_W-1:0] REQ_NONE = 2'd3;

    localparam int OVF_W = OVF_COUNT_BITS_DEF;
    localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

    localparam int DIR_ROWS       = 25;
    localparam int LONG_OVF_TICKS = 40;
    localparam int RANDOM_ITEMS   = 380;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_NS     = 2_000_000;

    typedef enum logic [1:0] {
        WAIT_RISE1 = 2'd0,
        WAIT_FALL  = 2'd1,
        WAIT_RISE2 = 2'd2,
        MEAS_IDLE  = 2'd3
    } meas_phase_t;

    typedef struct packed {
        logic              rising;
        logic              done;
        logic [DUTY_W-1:0] duty;
    } duty_word_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [CAP_W-1:0]      cap;
        logic                  typed;
        duty_word_t            want;
    } dir_row_t;

    // Result words that can be read straight off the protocol.
    localparam duty_word_t WANT_RISE = '{rising: 1'b1, done: 1'b0, duty: '0};
    localparam duty_word_t WANT_FALL = '{rising: 1'b0, done: 1'b0, duty: '0};
    localparam duty_word_t WANT_FULL = '{rising: 1'b1, done: 1'b1, duty: DUTY_FULL};
    localparam duty_word_t WANT_ZERO = '{rising: 1'b1, done: 1'b1, duty: '0};
    localparam duty_word_t NO_WANT   = '0;

    logic clk;
    logic rst_n;

    pdm_req_if req_ch ();
    pdm_res_if res_ch ();

    // Side tag carried with the word on the request channel.
    logic       word_typed;
    duty_word_t word_want;

    logic       allow_idle;
    int         errors;
    int         items_sent;
    duty_word_t pending_q [$];
    dir_row_t   dir_rows [DIR_ROWS];

    // Local copy of the measurement state.
    meas_phase_t      m_phase;
    logic [CAP_W-1:0] m_rise_stamp;
    logic [CAP_W-1:0] m_fall_stamp;
    logic [31:0]      m_high;
    logic [OVF_W-1:0] m_ovf;
    logic             m_rising;

    pwm_duty_measure_capture DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Timer clocks between two stamps, each counted overflow adding a full wrap.
    function automatic logic [31:0] span_clocks(input logic [CAP_W-1:0] prev,
                                                input logic [CAP_W-1:0] cap,
                                                input logic [OVF_W-1:0] ovf);
        return (32'(cap) - 32'(prev)) + (32'(ovf) << 16);
    endfunction

    task automatic clear_duty_model();
        m_phase      = MEAS_IDLE;
        m_rise_stamp = '0;
        m_fall_stamp = '0;
        m_high       = '0;
        m_ovf        = '0;
        m_rising     = 1'b1;
    endtask

    // Advance the local state by one request word and form its result word.
    task automatic step_duty_model(input logic [REQ_TYPE_W-1:0] kind,
                                   input logic [CAP_W-1:0] cap,
                                   output duty_word_t r);
        logic [31:0] low_clocks;
        logic [32:0] period;
        logic [63:0] scaled;
        r = '0;
        case (kind)
            REQ_START:
            begin
                m_phase  = WAIT_RISE1;
                m_rising = 1'b1;
            end
            REQ_OVF:
            begin
                if (m_ovf != OVF_MAX)
                    m_ovf = m_ovf + 1'b1;
            end
            REQ_CAPTURE:
            begin
                case (m_phase)
                    WAIT_RISE1:
                    begin
                        m_rise_stamp = cap;
                        m_ovf        = '0;
                        m_rising     = 1'b0;
                        m_phase      = WAIT_FALL;
                    end
                    WAIT_FALL:
                    begin
                        m_high       = span_clocks(m_rise_stamp, cap, m_ovf);
                        m_fall_stamp = cap;
                        m_ovf        = '0;
                        m_rising     = 1'b1;
                        m_phase      = WAIT_RISE2;
                    end
                    WAIT_RISE2:
                    begin
                        low_clocks = span_clocks(m_fall_stamp, cap, m_ovf);
                        period     = {1'b0, m_high} + {1'b0, low_clocks};
                        m_ovf      = '0;
                        m_phase    = MEAS_IDLE;
                        r.done     = 1'b1;
                        if (period != '0)
                        begin
                            scaled = 64'(m_high) * 64'(DUTY_FULL);
                            r.duty = DUTY_W'(scaled / 64'(period));
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.rising = m_rising;
    endtask

    // Predict on every accepted request word, check every accepted result word.
    always @(posedge clk)
    begin : duty_scoreboard
        duty_word_t predicted;
        duty_word_t got;
        duty_word_t want;
        if (!rst_n)
        begin
            clear_duty_model();
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                step_duty_model(req_ch.req_type, req_ch.capture_value, predicted);
                pending_q.push_back(word_typed ? word_want : predicted);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.rising = res_ch.capture_rising_edge;
                got.done   = res_ch.done_res;
                got.duty   = res_ch.duty_percent;
                if (pending_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: result word with none expected: edge %0d done %0d duty %0d",
                             $time, got.rising, got.done, got.duty);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.rising !== want.rising)
                    begin
                        errors = errors + 1;
                        $display("%0t: capture_rising_edge expected %0d, got %0d",
                                 $time, want.rising, got.rising);
                    end
                    if (got.done !== want.done)
                    begin
                        errors = errors + 1;
                        $display("%0t: done_res expected %0d, got %0d",
                                 $time, want.done, got.done);
                    end
                    if (got.duty !== want.duty)
                    begin
                        errors = errors + 1;
                        $display("%0t: duty_percent expected %0d, got %0d",
                                 $time, want.duty, got.duty);
                    end
                end
            end
        end
    end

    // Result side: ready drops in random bursts while idling is allowed.
    initial
    begin : result_sink
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (allow_idle && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge clk);
            end
        end
    end

    // Send one request word, with an optional gap before it; returns on a negedge.
    task automatic push_word(input logic [REQ_TYPE_W-1:0] kind, input logic [CAP_W-1:0] cap,
                             input logic typed, input duty_word_t want);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.capture_value <= cap;
        word_typed           <= typed;
        word_want            <= want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic push_plain(input logic [REQ_TYPE_W-1:0] kind, input logic [CAP_W-1:0] cap);
        push_word(kind, cap, 1'b0, NO_WANT);
    endtask

    // Timer stamps lean toward the ends of the range now and then.
    function automatic logic [CAP_W-1:0] rand_stamp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CAP_W'($urandom);
        endcase
    endfunction

    task automatic push_ovf_run(input int n);
        repeat (n) push_plain(REQ_OVF, CAP_W'($urandom));
    endtask

    function automatic int ovf_burst_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 0;
        else if (pick < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 12);
    endfunction

    // A start word followed by a number of captures with overflow bursts between.
    task automatic push_measurement(input int n_caps);
        push_plain(REQ_START, CAP_W'($urandom));
        for (int k = 0; k < n_caps; k++)
        begin
            push_ovf_run(ovf_burst_len());
            if ($urandom_range(0, 9) == 0)
                push_plain(REQ_NONE, CAP_W'($urandom));
            push_plain(REQ_CAPTURE, rand_stamp());
        end
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 3))
            0:       push_plain(REQ_NONE, CAP_W'($urandom));
            1:       push_plain(REQ_CAPTURE, rand_stamp());
            2:       push_plain(REQ_OVF, CAP_W'($urandom));
            default: push_plain(REQ_START, CAP_W'($urandom));
        endcase
    endtask

    // Stop offering words and wait until every expected result word has come.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus: directed table, long overflow run, then random measurements.
    initial
    begin : stimulus
        int random_end;
        int pick;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_START;
        req_ch.capture_value = '0;
        word_typed           = 1'b0;
        word_want            = NO_WANT;
        allow_idle           = 1'b1;
        errors               = 0;
        items_sent           = 0;
        rst_n                = 1'b0;

        dir_rows = '{
            // Capture, overflow and the unused code before any start are ignored.
            '{REQ_CAPTURE, 16'h1234, 1'b1, WANT_RISE},
            '{REQ_OVF,     16'hFFFF, 1'b1, WANT_RISE},
            '{REQ_NONE,    16'hA5A5, 1'b1, WANT_RISE},
            // Start in the middle of a measurement restarts it.
            '{REQ_START,   16'h0000, 1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'h0000, 1'b1, WANT_FALL},
            '{REQ_START,   16'h5A5A, 1'b1, WANT_RISE},
            // Full duty: the low interval is empty.
            '{REQ_CAPTURE, 16'h0000, 1'b1, WANT_FALL},
            '{REQ_CAPTURE, 16'hFFFF, 1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'hFFFF, 1'b1, WANT_FULL},
            // Zero period.
            '{REQ_START,   16'hFFFF, 1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'd100,  1'b1, WANT_FALL},
            '{REQ_CAPTURE, 16'd100,  1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'd100,  1'b1, WANT_ZERO},
            // Zero high time with a nonzero period.
            '{REQ_START,   16'h0000, 1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'd5,    1'b1, WANT_FALL},
            '{REQ_CAPTURE, 16'd5,    1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'd10,   1'b1, WANT_ZERO},
            // Timer stamps that wrap, with overflows in both intervals.
            '{REQ_START,   16'h0000, 1'b1, WANT_RISE},
            '{REQ_CAPTURE, 16'hFFFF, 1'b1, WANT_FALL},
            '{REQ_OVF,     16'h0000, 1'b0, NO_WANT},
            '{REQ_CAPTURE, 16'h0001, 1'b0, NO_WANT},
            '{REQ_OVF,     16'h00FF, 1'b0, NO_WANT},
            '{REQ_OVF,     16'hFF00, 1'b0, NO_WANT},
            '{REQ_CAPTURE, 16'h8000, 1'b0, NO_WANT},
            // A capture after the measurement has completed is ignored.
            '{REQ_CAPTURE, 16'hFFFF, 1'b1, WANT_RISE}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            push_word(dir_rows[i].kind, dir_rows[i].cap, dir_rows[i].typed, dir_rows[i].want);

        // Hold the request side until every result word has come back.
        wait_drained();

        // A long overflow run inside the high interval, back to back.
        allow_idle = 1'b0;
        push_plain(REQ_START, 16'h0000);
        push_plain(REQ_CAPTURE, 16'h0000);
        push_ovf_run(LONG_OVF_TICKS);
        push_plain(REQ_CAPTURE, 16'h0000);
        push_ovf_run(2);
        push_plain(REQ_CAPTURE, 16'h0001);
        wait_drained();

        // Random part: mostly complete measurements, some cut short, some noise.
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end)
        begin
            if (items_sent >= random_end - QUIET_TAIL)
                allow_idle = 1'b0;
            else
                allow_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                push_measurement(3);
            else if (pick < 88)
                push_measurement($urandom_range(1, 2));
            else
                push_noise();
        end

        // Let the last result words drain, then report.
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pdm_pkg.sv
hw/rtl/pdm_ifs.sv
hw/rtl/pwm_duty_measure_capture.sv
tb/tb_pwm_duty_measure_capture.sv
